// ===== design/rtc_calibration_encoder_macros.svh =====
// Assertion macros shared by the calibration encoder modules.
// Each macro expects signals named clk and rst in the module that uses it.
`ifndef RTC_CALIBRATION_ENCODER_MACROS_SVH
`define RTC_CALIBRATION_ENCODER_MACROS_SVH

// The property must hold in the same cycle as the condition.
`define RCE_ASSERT_NOW(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("rtc calibration encoder check failed");

// The property must hold in the cycle after the condition.
`define RCE_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("rtc calibration encoder check failed");

`endif

// ===== design/rtc_cal_pkg.sv =====
`default_nettype none

package rtc_cal_pkg;

  localparam int ADJ_W = 17;
  localparam int OSC_W = 2;
  localparam int N_W = 26;
  localparam int Q_W = 16;
  localparam int S_W = 18;
  localparam int M_W = 27;
  localparam int S_DATA_W = 24;
  localparam int S_USER_W = 2;
  localparam int M_DATA_W = 24;

  localparam int SCALE_MUL = 1000;
  localparam int SCALE_RND = 953;
  localparam int SCALE_DIV = 1907;

  // Reciprocal of the divisor, exact for every dividend below 2**N_W.
  localparam int RECIP_SH = 37;
  localparam logic [M_W-1:0] RECIP_MUL =
    M_W'(((64'd1 << RECIP_SH) + 64'(SCALE_DIV) - 64'd1) / 64'(SCALE_DIV));

  // Adjustment limits; both bounds are excluded from the legal range.
  localparam int XT_ADJ_LO = -610;
  localparam int XT_ADJ_HI = 242;
  localparam int RC_ADJ_LO = -65536;
  localparam int RC_ADJ_HI = 65520;

  localparam logic [OSC_W-1:0] OSC_XT = 2'd0;
  localparam logic [OSC_W-1:0] OSC_RC = 2'd1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_OSC = 2'd1,
    ST_RANGE   = 2'd2
  } status_t;

  typedef struct packed {
    logic             valid;
    logic [OSC_W-1:0] osc;
    logic             neg;
    status_t          status;
  } tag_t;

endpackage

`default_nettype wire

// ===== design/rtc_cal_divider.sv =====
`default_nettype none
`include "rtc_calibration_encoder_macros.svh"

module rtc_cal_divider (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    en,
  input  wire rtc_cal_pkg::tag_t       tag,
  input  wire logic [rtc_cal_pkg::N_W-1:0] n,
  output rtc_cal_pkg::tag_t            res_tag,
  output logic [rtc_cal_pkg::Q_W-1:0]  q
);
  import rtc_cal_pkg::*;

  logic [N_W+M_W-1:0] prod;
  logic [Q_W-1:0]     q_next;

  // The quotient is the high part of the product with the scaled reciprocal.
  assign prod   = {{M_W{1'b0}}, n} * {{N_W{1'b0}}, RECIP_MUL};
  assign q_next = prod[RECIP_SH +: Q_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      res_tag.valid <= 1'b0;
    end else if (en) begin
      res_tag <= tag;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= q_next;
    end
  end

  `RCE_ASSERT_NEXT(div_exact, en && tag.valid, (32'(q) * 32'(SCALE_DIV) <= 32'($past(n))) && (32'($past(n)) - 32'(q) * 32'(SCALE_DIV) < 32'(SCALE_DIV)))
  `RCE_ASSERT_NEXT(div_hold, !en && res_tag.valid, $stable(res_tag) && $stable(q))
  `RCE_ASSERT_NOW(div_xt_span, res_tag.valid && res_tag.status == ST_OK && res_tag.osc == OSC_XT, q <= 16'd319)

endmodule

`default_nettype wire

// ===== design/rtc_calibration_encoder.sv =====
// Channel  Direction  Fields
// s        in         tuser: osc_select; tdata: ppm_adjust
// m        out        tdata: cal_high, cal_low, xt_range, status
//
// One item enters per cycle unless m holds an untaken item; its result is registered through each stage in order.
// The stages are input register, scaled magnitude, reciprocal multiply and output.
// The reciprocal multiply sets the clock rate of the path.
// All stages advance together; s_tready is low only while m holds an untaken item.
// Reset clears the valid bits of every stage and of the output.
`default_nettype none
`include "rtc_calibration_encoder_macros.svh"

module rtc_calibration_encoder (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // ppm_adjust [16:0], zeros above
  input  wire logic [rtc_cal_pkg::S_DATA_W-1:0]  s_tdata,
  // osc_select [1:0]
  input  wire logic [rtc_cal_pkg::S_USER_W-1:0]  s_tuser,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // cal_high [7:0], cal_low [15:8], xt_range [17:16], status [19:18], zeros above
  output logic [rtc_cal_pkg::M_DATA_W-1:0]       m_tdata
);
  import rtc_cal_pkg::*;

  logic                    en;
  logic                    a_valid;
  logic [OSC_W-1:0]        a_osc;
  logic signed [ADJ_W-1:0] a_adj;

  tag_t             b_tag;
  tag_t             b_tag_next;
  logic [N_W-1:0]   b_n;
  logic [N_W-1:0]   b_n_next;
  logic [ADJ_W-1:0] mag;

  tag_t           res_tag;
  logic [Q_W-1:0] q;

  logic signed [S_W-1:0] q_s;
  logic signed [S_W-1:0] s;
  logic signed [S_W-1:0] p64;
  logic signed [S_W-1:0] p128;
  logic signed [S_W-1:0] p192;
  logic [1:0]            sh;
  logic [7:0]            mark;
  logic [7:0]            mask;

  logic [7:0] cal_high;
  logic [7:0] cal_high_next;
  logic [7:0] cal_low;
  logic [7:0] cal_low_next;
  logic [1:0] xt_range;
  logic [1:0] xt_range_next;
  status_t    status;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_osc <= s_tuser;
      a_adj <= signed'(s_tdata[ADJ_W-1:0]);
    end
  end

  always_comb begin
    b_tag_next.valid = a_valid;
    b_tag_next.osc   = a_osc;
    b_tag_next.neg   = a_adj[ADJ_W-1];
    if (a_osc != OSC_XT && a_osc != OSC_RC) begin
      b_tag_next.status = ST_BAD_OSC;
    end else if (a_osc == OSC_XT && (a_adj <= XT_ADJ_LO || a_adj >= XT_ADJ_HI)) begin
      b_tag_next.status = ST_RANGE;
    end else if (a_osc == OSC_RC && (a_adj <= RC_ADJ_LO || a_adj >= RC_ADJ_HI)) begin
      b_tag_next.status = ST_RANGE;
    end else begin
      b_tag_next.status = ST_OK;
    end
    mag      = a_adj[ADJ_W-1] ? ADJ_W'(-a_adj) : ADJ_W'(a_adj);
    b_n_next = {{(N_W-ADJ_W){1'b0}}, mag} * N_W'(SCALE_MUL) + N_W'(SCALE_RND);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_tag.valid <= 1'b0;
    end else if (en) begin
      b_tag <= b_tag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_n <= b_n_next;
    end
  end

  rtc_cal_divider u_divider (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .tag     (b_tag),
    .n       (b_n),
    .res_tag (res_tag),
    .q       (q)
  );

  always_comb begin
    q_s  = signed'({{(S_W-Q_W){1'b0}}, q});
    s    = res_tag.neg ? -q_s : q_s;
    p64  = s + 18'sd64;
    p128 = s + 18'sd128;
    p192 = s + 18'sd192;
    sh   = 2'd0;
    mark = 8'h00;
    mask = 8'hFF;
    cal_high_next = 8'h00;
    cal_low_next  = 8'h00;
    xt_range_next = 2'd0;
    if (res_tag.status != ST_OK) begin
      cal_high_next = 8'h00;
    end else if (res_tag.osc == OSC_XT) begin
      if (s > 18'sd63) begin
        cal_high_next = {2'b10, s[6:1]};
      end else if (s > -18'sd65) begin
        cal_high_next = {1'b0, s[6:0]};
      end else if (s > -18'sd129) begin
        xt_range_next = 2'd1;
        cal_high_next = {1'b0, p64[6:0]};
      end else if (s > -18'sd193) begin
        xt_range_next = 2'd2;
        cal_high_next = {1'b0, p128[6:0]};
      end else if (s > -18'sd257) begin
        xt_range_next = 2'd3;
        cal_high_next = {1'b0, p192[6:0]};
      end else begin
        xt_range_next = 2'd3;
        cal_high_next = p192[8:1];
      end
    end else begin
      if (s > 18'sd32767) begin
        sh = 2'd3;
        mark = 8'hC0;
      end else if (s > 18'sd16383) begin
        sh = 2'd2;
        mark = 8'h80;
      end else if (s > 18'sd8191) begin
        sh = 2'd1;
        mark = 8'h40;
      end else if (s >= 18'sd0) begin
        sh = 2'd0;
      end else if (s > -18'sd8193) begin
        mask = 8'h3F;
      end else if (s > -18'sd16385) begin
        sh = 2'd1;
        mask = 8'h7F;
      end else if (s > -18'sd32769) begin
        sh = 2'd2;
        mask = 8'hBF;
      end else begin
        sh = 2'd3;
      end
      cal_low_next  = 8'(s >>> sh);
      cal_high_next = (8'(s >>> ({2'b00, sh} + 4'd8)) | mark) & mask;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= res_tag.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cal_high <= cal_high_next;
      cal_low  <= cal_low_next;
      xt_range <= xt_range_next;
      status   <= res_tag.status;
    end
  end

  assign m_tdata = {4'b0000, status, xt_range, cal_low, cal_high};

  `RCE_ASSERT_NOW(err_zero, m_tvalid && status != ST_OK, cal_high == 8'h00 && cal_low == 8'h00 && xt_range == 2'd0)
  `RCE_ASSERT_NOW(rc_no_range, m_tvalid && cal_low != 8'h00, xt_range == 2'd0)
  `RCE_ASSERT_NOW(status_code, m_tvalid, status == ST_OK || status == ST_BAD_OSC || status == ST_RANGE)

endmodule

`default_nettype wire
